/* sv/rem_pkg.sv */
`default_nettype none

package rem_pkg;

    // Grid geometry
    localparam int FFT_POINTS            = 2048;
    localparam int SUBCARRIERS_PER_BLOCK = 12;
    localparam int SYMBOLS_PER_SUBFRAME  = 14;
    localparam int SLOT_SYMBOLS          = 7;
    localparam int MAX_BLOCKS            = FFT_POINTS / SUBCARRIERS_PER_BLOCK;
    localparam int LAST_SYMBOL           = SYMBOLS_PER_SUBFRAME - 1;

    // Reference writes allowed ahead of one data write
    localparam int PILOTS_MAX = 2;

    // Reset values of the configuration registers
    localparam int RESET_BLOCKS  = 16;
    localparam int RESET_CONTROL = 2;
    localparam int RESET_PILOT   = 100;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CELL_IDENTITY   = 3'd0,
        REG_RESOURCE_BLOCKS = 3'd1,
        REG_CONTROL_SYMBOLS = 3'd2,
        REG_PORT_COUNT_CODE = 3'd3,
        REG_SUBFRAME_NUMBER = 3'd4,
        REG_PILOT_MARKER    = 3'd5
    } cfg_reg_t;

    // Port count codes
    localparam logic [1:0] PORTS_ONE = 2'd0;
    localparam logic [1:0] PORTS_TWO = 2'd1;

    // Input beat
    typedef struct packed {
        logic signed [15:0] sample_real;
        logic signed [15:0] sample_imag;
    } sample_t;

    // Output beat
    typedef struct packed {
        logic [10:0]        fft_bin;
        logic [3:0]         symbol_index;
        logic signed [15:0] element_real;
        logic signed [15:0] element_imag;
        logic               is_reference;
        logic               run_end;
        logic               grid_done;
    } element_t;

    // Configuration as seen by the grid walker, with derived values
    typedef struct packed {
        logic [2:0]         cell_shift;
        logic [10:0]        width;
        logic [9:0]         half;
        logic [2:0]         control_symbols;
        logic [1:0]         port_count_code;
        logic [3:0]         subframe_number;
        logic signed [15:0] pilot_marker;
    } cfg_t;

    // Remainder by six through a reciprocal multiply and one correction step.
    function automatic logic [2:0] mod6(input logic [10:0] x);
        logic [20:0] prod;
        logic [8:0]  quot;
        logic [11:0] rem;
        prod = 21'(x) * 21'(683);
        quot = prod[20:12];
        rem  = 12'(x) - (12'(quot) * 12'd6);
        if (rem >= 12'd6)
        begin
            rem = rem - 12'd6;
        end
        return rem[2:0];
    endfunction

endpackage

`default_nettype wire

/* sv/rem_cfg.sv */
`default_nettype none

module rem_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rem_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [rem_pkg::CFG_DATA_W-1:0]      cfg_data,
    output rem_pkg::cfg_t                            cfg
);

    logic [8:0]         cell_identity_reg;
    logic [6:0]         resource_blocks_reg;
    logic [2:0]         control_symbols_reg;
    logic [1:0]         port_count_code_reg;
    logic [3:0]         subframe_number_reg;
    logic signed [15:0] pilot_marker_reg;

    logic [6:0]  blocks_min;
    logic [6:0]  blocks_sat;
    logic [10:0] width;

    // Writes are taken in every cycle.
    assign cfg_ready = 1'b1;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_identity_reg   <= '0;
            resource_blocks_reg <= 7'(rem_pkg::RESET_BLOCKS);
            control_symbols_reg <= 3'(rem_pkg::RESET_CONTROL);
            port_count_code_reg <= '0;
            subframe_number_reg <= '0;
            pilot_marker_reg    <= 16'(rem_pkg::RESET_PILOT);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rem_pkg::REG_CELL_IDENTITY:   cell_identity_reg   <= cfg_data[8:0];
                rem_pkg::REG_RESOURCE_BLOCKS: resource_blocks_reg <= cfg_data[6:0];
                rem_pkg::REG_CONTROL_SYMBOLS: control_symbols_reg <= cfg_data[2:0];
                rem_pkg::REG_PORT_COUNT_CODE: port_count_code_reg <= cfg_data[1:0];
                rem_pkg::REG_SUBFRAME_NUMBER: subframe_number_reg <= cfg_data[3:0];
                rem_pkg::REG_PILOT_MARKER:    pilot_marker_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Used width: zero blocks count as one, more blocks than fit in the FFT saturate to that maximum.
    always_comb
    begin
        blocks_min = (resource_blocks_reg == 7'd0) ? 7'd1 : resource_blocks_reg;
        blocks_sat = (32'(blocks_min) > rem_pkg::MAX_BLOCKS)
                   ? 7'(rem_pkg::MAX_BLOCKS) : blocks_min;
        width      = 11'(blocks_sat * 11'(rem_pkg::SUBCARRIERS_PER_BLOCK));
    end

    always_comb
    begin
        cfg.cell_shift      = rem_pkg::mod6({2'b00, cell_identity_reg});
        cfg.width           = width;
        cfg.half            = width[10:1];
        cfg.control_symbols = control_symbols_reg;
        cfg.port_count_code = port_count_code_reg;
        cfg.subframe_number = subframe_number_reg;
        cfg.pilot_marker    = pilot_marker_reg;
    end

endmodule

`default_nettype wire

/* sv/rem_walk.sv */
`default_nettype none

module rem_walk (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rem_pkg::cfg_t     cfg,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire rem_pkg::sample_t  sample,
    input  wire logic              load_ok,
    output logic                   fire,
    output rem_pkg::element_t      result
);

    // Held input beat
    logic              item_valid_reg;
    logic              item_valid_next;
    rem_pkg::sample_t  item_reg;

    // Grid position and reference writes issued for the held beat
    logic [3:0]  sym_reg;
    logic [3:0]  sym_next;
    logic [10:0] sc_reg;
    logic [10:0] sc_next;
    logic [1:0]  pilots_reg;
    logic [1:0]  pilots_next;

    logic [3:0]  cur_sym;
    logic [10:0] cur_sc;
    logic [3:0]  inc_sym;
    logic [10:0] inc_sc;
    logic [3:0]  adv_sym;
    logic [10:0] adv_sc;

    logic [2:0]  line;
    logic        slot_half;
    logic        slot;
    logic [2:0]  k6;
    logic [3:0]  base_sum;
    logic [2:0]  tone_a;
    logic [2:0]  tone_b;
    logic        multi_port;
    logic        four_port;
    logic        pilot_here;
    logic        emit_pilot;
    logic        consume;
    logic [10:0] bin;

    // One normalize step: past the width goes to the next symbol, past the
    // subframe goes back to the first data symbol.
    function automatic logic [14:0] normalize(input logic [3:0] sym, input logic [10:0] sc,
                                              input rem_pkg::cfg_t c);
        logic [3:0]  s;
        logic [10:0] k;
        s = sym;
        k = sc;
        if (k >= c.width)
        begin
            k = '0;
            s = s + 4'd1;
        end
        if (32'(s) >= rem_pkg::SYMBOLS_PER_SUBFRAME)
        begin
            s = {1'b0, c.control_symbols};
            k = '0;
        end
        return {s, k};
    endfunction

    // Position in use this cycle and the one after it
    always_comb
    begin
        {cur_sym, cur_sc} = normalize(sym_reg, sc_reg, cfg);
        inc_sym           = cur_sym;
        inc_sc            = cur_sc + 11'd1;
        {adv_sym, adv_sc} = normalize(inc_sym, inc_sc, cfg);
    end

    // Cell-specific reference pattern
    always_comb
    begin
        slot_half  = (32'(cur_sym) >= rem_pkg::SLOT_SYMBOLS);
        line       = slot_half ? 3'(cur_sym - 4'(rem_pkg::SLOT_SYMBOLS)) : cur_sym[2:0];
        slot       = slot_half ^ 1'b0 ^ ({cfg.subframe_number, 1'b0} == 5'd1);
        k6         = rem_pkg::mod6(cur_sc);
        multi_port = (cfg.port_count_code != rem_pkg::PORTS_ONE);
        four_port  = multi_port && (cfg.port_count_code != rem_pkg::PORTS_TWO);

        // Tone offset of the first port pair on this line
        if (line == 3'd1)
        begin
            base_sum = {1'b0, cfg.cell_shift} + (slot ? 4'd3 : 4'd0);
        end
        else
        begin
            base_sum = {1'b0, cfg.cell_shift} + ((line == 3'd0) ? 4'd0 : 4'd3);
        end
        tone_a = (base_sum >= 4'd6) ? 3'(base_sum - 4'd6) : base_sum[2:0];
        tone_b = (tone_a >= 3'd3) ? (tone_a - 3'd3) : (tone_a + 3'd3);

        if (line == 3'd0 || line == 3'(rem_pkg::SLOT_SYMBOLS - 3))
        begin
            pilot_here = (k6 == tone_a) || (multi_port && k6 == tone_b);
        end
        else if (line == 3'd1 && four_port)
        begin
            pilot_here = (k6 == tone_a) || (k6 == tone_b);
        end
        else
        begin
            pilot_here = 1'b0;
        end
    end

    // Bin mapping around DC, lower half at the top of the FFT
    always_comb
    begin
        if (cur_sc < {1'b0, cfg.half})
        begin
            bin = 11'(rem_pkg::FFT_POINTS - 32'(cfg.half) + 32'(cur_sc));
        end
        else
        begin
            bin = 11'(cur_sc - {1'b0, cfg.half} + 11'd1);
        end
    end

    // Emission: a reference write when one is due, else the data write
    always_comb
    begin
        emit_pilot   = pilot_here && (32'(pilots_reg) < rem_pkg::PILOTS_MAX);
        fire         = item_valid_reg && load_ok;
        consume      = fire && !emit_pilot;
        sample_ready = !item_valid_reg || consume;

        result.fft_bin      = bin;
        result.symbol_index = cur_sym;
        result.element_real = emit_pilot ? cfg.pilot_marker : item_reg.sample_real;
        result.element_imag = emit_pilot ? 16'sd0 : item_reg.sample_imag;
        result.is_reference = emit_pilot;
        result.run_end      = !emit_pilot;
        result.grid_done    = !emit_pilot && (32'(cur_sym) == rem_pkg::LAST_SYMBOL)
                            && ({1'b0, cur_sc} + 12'd1 >= {1'b0, cfg.width});
    end

    // Next state
    always_comb
    begin
        item_valid_next = item_valid_reg;
        sym_next        = sym_reg;
        sc_next         = sc_reg;
        pilots_next     = pilots_reg;
        if (sample_valid && sample_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (consume)
        begin
            item_valid_next = 1'b0;
        end
        if (fire)
        begin
            sym_next    = adv_sym;
            sc_next     = adv_sc;
            pilots_next = emit_pilot ? (pilots_reg + 2'd1) : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            sym_reg        <= 4'(rem_pkg::RESET_CONTROL);
            sc_reg         <= '0;
            pilots_reg     <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            sym_reg        <= sym_next;
            sc_reg         <= sc_next;
            pilots_reg     <= pilots_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            item_reg <= sample;
        end
    end

endmodule

`default_nettype wire

/* sv/rem_out.sv */
`default_nettype none

module rem_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire rem_pkg::element_t  result,
    output logic                    load_ok,
    output logic                    element_valid,
    input  wire logic               element_ready,
    output rem_pkg::element_t       element
);

    logic               valid_reg;
    logic               valid_next;
    rem_pkg::element_t  data_reg;

    // The register takes a new beat when empty or when its beat leaves.
    always_comb
    begin
        load_ok    = !valid_reg || element_ready;
        valid_next = fire || (valid_reg && !element_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= result;
        end
    end

    assign element_valid = valid_reg;
    assign element       = data_reg;

endmodule

`default_nettype wire

/* sv/resource_element_mapper_top.sv */
// Resource element mapper: each sample beat is one modulated data symbol and
// leaves as one data write, preceded by zero, one or two reference writes when
// the grid walk reaches cell-specific reference positions first. The block takes
// one sample beat per cycle while no reference write is due and the output side
// is not stalled; a beat that meets reference positions holds the input until
// its reference writes are issued, because the output register issues one write
// per cycle when not stalled. The data write of a beat passes through the input
// register and then the output register. Configuration writes are taken in every
// cycle and must be made while no sample is in flight.
`default_nettype none

module resource_element_mapper_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rem_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rem_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             sample_valid,
    output logic                                  sample_ready,
    input  wire rem_pkg::sample_t                 sample,
    output logic                                  element_valid,
    input  wire logic                             element_ready,
    output rem_pkg::element_t                     element
);

    rem_pkg::cfg_t      cfg;
    rem_pkg::element_t  result;
    logic               load_ok;
    logic               fire;

    // Configuration registers
    rem_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register and grid walk
    rem_walk u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .load_ok      (load_ok),
        .fire         (fire),
        .result       (result)
    );

    // Output register
    rem_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .result        (result),
        .load_ok       (load_ok),
        .element_valid (element_valid),
        .element_ready (element_ready),
        .element       (element)
    );

endmodule

`default_nettype wire
